// ----- rtl/hepc_pkg.sv -----
package hepc_pkg;

   // Datapath widths: dx, dy are 25 bits, scaled by 2^24, with headroom for CORDIC gain
   localparam int XW = 52;
   localparam int ZW = 32;
   localparam int DW = 25;
   localparam int POS_W = 24;
   localparam int HEAD_W = 16;
   localparam int CMD_W = 17;
   localparam int ERR_W = 18;
   localparam int SCALE_SHIFT = 24;
   localparam int ROUND_SHIFT = 16;

   localparam int CORDIC_STAGES_DEFAULT = 16;

   // Angle constants, Q2.29 radians
   localparam logic signed [ZW-1:0] HALF_PI_Q29 = 32'sd843314857;
   localparam logic signed [ZW-1:0] QUARTER_PI_Q29 = 32'sd421657428;
   localparam logic signed [ZW:0] ROUND_HALF = 33'sd32768;

   // Heading error constants, Q3.13 radians
   localparam logic signed [ERR_W-1:0] PI_Q13 = 18'sd25736;
   localparam logic signed [ERR_W-1:0] NEG_PI_Q13 = -18'sd25736;
   localparam logic signed [ERR_W-1:0] TWO_PI_Q13 = 18'sd51472;

   // Configuration register indexes
   localparam logic CSR_GOAL_X = 1'b0;
   localparam logic CSR_GOAL_Y = 1'b1;

   // Vector carried down the rotation chain
   typedef struct packed {
      logic signed [XW-1:0]     x;
      logic signed [XW-1:0]     y;
      logic signed [ZW-1:0]     z;
      logic signed [HEAD_W-1:0] heading;
      logic                     at_goal;
   } hepc_vec_type;

   // Truncating quotient of two non-negative values by shift and subtract, used at elaboration
   function automatic longint series_quotient(input longint num, input longint den);
      longint rem;
      longint quo;
      rem = 0;
      quo = 0;
      for (int b = 62; b >= 0; b--) begin
         rem = (rem << 1) | ((num >>> b) & longint'(1));
         quo = quo << 1;
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | longint'(1);
         end
      end
      return quo;
   endfunction

   // atan(2^-idx) in Q2.29 by a truncated alternating series in Q0.60, used at elaboration
   function automatic logic signed [ZW-1:0] atan_entry(input int unsigned idx);
      longint power;
      longint acc;
      longint term;
      longint divisor;
      acc = 0;
      if (idx == 0) begin
         return QUARTER_PI_Q29;
      end
      if (idx > 30) begin
         return '0;
      end
      power = longint'(1) << (60 - idx);
      for (int k = 0; k < 32; k++) begin
         if (power != 0) begin
            divisor = longint'(2 * k + 1);
            term = series_quotient(power, divisor);
            if ((k & 1) != 0) begin
               acc = acc - term;
            end else begin
               acc = acc + term;
            end
            power = power >>> (2 * idx);
         end
      end
      return ZW'((acc + (longint'(1) << 30)) >>> 31);
   endfunction

endpackage

// ----- rtl/hepc_front.sv -----
module hepc_front
   import hepc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [POS_W-1:0]  goal_x,
   input  logic signed [POS_W-1:0]  goal_y,
   input  logic                     s_valid,
   output logic                     s_ready,
   input  logic signed [POS_W-1:0]  robot_x,
   input  logic signed [POS_W-1:0]  robot_y,
   input  logic signed [HEAD_W-1:0] robot_heading,
   output logic                     m_valid,
   input  logic                     m_ready,
   output hepc_vec_type             m_vec
);

   logic signed [DW-1:0] dx;
   logic signed [DW-1:0] dy;
   logic signed [DW-1:0] rot_x;
   logic signed [DW-1:0] rot_y;
   logic signed [ZW-1:0] rot_z;
   hepc_vec_type         vec_in;
   hepc_vec_type         vec_ff;
   logic                 valid_ff;
   logic                 valid_in;

   // Form the offset to the goal
   assign dx = {goal_x[POS_W-1], goal_x} - {robot_x[POS_W-1], robot_x};
   assign dy = {goal_y[POS_W-1], goal_y} - {robot_y[POS_W-1], robot_y};

   // Rotate the left half plane into the right one by a quarter turn
   always_comb begin
      rot_x = dx;
      rot_y = dy;
      rot_z = '0;
      if (dx[DW-1]) begin
         if (!dy[DW-1]) begin
            rot_x = dy;
            rot_y = -dx;
            rot_z = HALF_PI_Q29;
         end else begin
            rot_x = -dy;
            rot_y = dx;
            rot_z = -HALF_PI_Q29;
         end
      end
   end

   always_comb begin
      vec_in.x = {{(XW - DW - SCALE_SHIFT){rot_x[DW-1]}}, rot_x, {SCALE_SHIFT{1'b0}}};
      vec_in.y = {{(XW - DW - SCALE_SHIFT){rot_y[DW-1]}}, rot_y, {SCALE_SHIFT{1'b0}}};
      vec_in.z = rot_z;
      vec_in.heading = robot_heading;
      vec_in.at_goal = (dx == '0) && (dy == '0);
   end

   // Stage register: load when empty or draining
   assign s_ready = !valid_ff || m_ready;
   assign valid_in = s_ready ? s_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (s_ready && s_valid) begin
         vec_ff <= vec_in;
      end
   end

   assign m_valid = valid_ff;
   assign m_vec = vec_ff;

endmodule

// ----- rtl/hepc_cell.sv -----
module hepc_cell
   import hepc_pkg::*;
#(
   parameter int STAGE_INDEX = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         s_valid,
   output logic         s_ready,
   input  hepc_vec_type s_vec,
   output logic         m_valid,
   input  logic         m_ready,
   output hepc_vec_type m_vec
);

   localparam logic signed [ZW-1:0] ATAN_STEP = atan_entry(STAGE_INDEX);

   logic signed [XW-1:0] x_shift;
   logic signed [XW-1:0] y_shift;
   hepc_vec_type         vec_in;
   hepc_vec_type         vec_ff;
   logic                 valid_ff;
   logic                 valid_in;

   // Rotate toward the x axis by one micro-angle
   assign x_shift = s_vec.x >>> STAGE_INDEX;
   assign y_shift = s_vec.y >>> STAGE_INDEX;

   always_comb begin
      vec_in = s_vec;
      if (!s_vec.y[XW-1]) begin
         vec_in.x = s_vec.x + y_shift;
         vec_in.y = s_vec.y - x_shift;
         vec_in.z = s_vec.z + ATAN_STEP;
      end else begin
         vec_in.x = s_vec.x - y_shift;
         vec_in.y = s_vec.y + x_shift;
         vec_in.z = s_vec.z - ATAN_STEP;
      end
   end

   // Stage register: load when empty or draining
   assign s_ready = !valid_ff || m_ready;
   assign valid_in = s_ready ? s_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (s_ready && s_valid) begin
         vec_ff <= vec_in;
      end
   end

   assign m_valid = valid_ff;
   assign m_vec = vec_ff;

endmodule

// ----- rtl/hepc_finish.sv -----
module hepc_finish
   import hepc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    s_valid,
   output logic                    s_ready,
   input  hepc_vec_type            s_vec,
   output logic                    m_valid,
   input  logic                    m_ready,
   output logic signed [CMD_W-1:0] turn_command
);

   logic signed [ZW:0]       z_round;
   logic signed [CMD_W-1:0]  angle;
   logic signed [ERR_W-1:0]  err_in;
   logic signed [ERR_W-1:0]  err_ff;
   logic                     goal_ff;
   logic                     err_valid_ff;
   logic                     err_valid_in;
   logic                     err_ready;
   logic signed [ERR_W-1:0]  wrap;
   logic signed [CMD_W-1:0]  cmd_in;
   logic signed [CMD_W-1:0]  cmd_ff;
   logic                     cmd_valid_ff;
   logic                     cmd_valid_in;

   // Round the angle to Q3.13 and take off the heading
   assign z_round = {s_vec.z[ZW-1], s_vec.z} + ROUND_HALF;
   assign angle = z_round[ZW:ROUND_SHIFT];
   assign err_in = {angle[CMD_W-1], angle}
                 - {{(ERR_W - HEAD_W){s_vec.heading[HEAD_W-1]}}, s_vec.heading};

   assign s_ready = !err_valid_ff || err_ready;
   assign err_valid_in = s_ready ? s_valid : err_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         err_valid_ff <= 1'b0;
      end else begin
         err_valid_ff <= err_valid_in;
      end
      if (s_ready && s_valid) begin
         err_ff <= err_in;
         goal_ff <= s_vec.at_goal;
      end
   end

   // Wrap into (-pi, pi] and double; force zero on the goal
   always_comb begin
      wrap = err_ff;
      if (err_ff > PI_Q13) begin
         wrap = err_ff - TWO_PI_Q13;
      end else if (err_ff <= NEG_PI_Q13) begin
         wrap = err_ff + TWO_PI_Q13;
      end
      cmd_in = goal_ff ? '0 : {wrap[CMD_W-2:0], 1'b0};
   end

   // Output register: holds a beat while the sink stalls
   assign err_ready = !cmd_valid_ff || m_ready;
   assign cmd_valid_in = err_ready ? err_valid_ff : cmd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
      if (err_ready && err_valid_ff) begin
         cmd_ff <= cmd_in;
      end
   end

   assign m_valid = cmd_valid_ff;
   assign turn_command = cmd_ff;

endmodule

// ----- rtl/heading_error_p_controller.sv -----
// Proportional heading controller. Each beat on req_ carries one robot pose; the block
// answers with one beat on rsp_ holding twice the signed angle, wrapped into (-pi, pi], from
// the robot heading to the goal point held in the csr_ registers (zero when the robot sits
// on the goal). The angle to the goal comes from a vectoring CORDIC built as a chain of
// CORDIC_STAGES rotation cells, each with its own stage register. A pose passes through one
// offset stage, the rotation cells and two output stages, and a new pose can enter every
// cycle; req_tready falls only when every stage is full and rsp_tready is low. Write the
// goal registers only while no pose is in flight.
module heading_error_p_controller
   import hepc_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic        csr_addr,
   input  logic [23:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // robot_x[23:0], robot_y[47:24], robot_heading[63:48]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // turn_command[16:0], zero fill[23:17]
);

   logic signed [POS_W-1:0] goal_x_ff;
   logic signed [POS_W-1:0] goal_y_ff;
   logic signed [CMD_W-1:0] turn_command;
   logic                    chain_valid [CORDIC_STAGES+1];
   logic                    chain_ready [CORDIC_STAGES+1];
   hepc_vec_type            chain_vec   [CORDIC_STAGES+1];

   // Goal registers
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= '0;
         goal_y_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_GOAL_X: goal_x_ff <= csr_wdata;
            CSR_GOAL_Y: goal_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   hepc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .goal_x        (goal_x_ff),
      .goal_y        (goal_y_ff),
      .s_valid       (req_tvalid),
      .s_ready       (req_tready),
      .robot_x       (req_tdata[23:0]),
      .robot_y       (req_tdata[47:24]),
      .robot_heading (req_tdata[63:48]),
      .m_valid       (chain_valid[0]),
      .m_ready       (chain_ready[0]),
      .m_vec         (chain_vec[0])
   );

   // Rotation chain
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      hepc_cell #(
         .STAGE_INDEX (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .s_valid (chain_valid[i]),
         .s_ready (chain_ready[i]),
         .s_vec   (chain_vec[i]),
         .m_valid (chain_valid[i+1]),
         .m_ready (chain_ready[i+1]),
         .m_vec   (chain_vec[i+1])
      );
   end

   hepc_finish u_finish (
      .clock        (clock),
      .reset        (reset),
      .s_valid      (chain_valid[CORDIC_STAGES]),
      .s_ready      (chain_ready[CORDIC_STAGES]),
      .s_vec        (chain_vec[CORDIC_STAGES]),
      .m_valid      (rsp_tvalid),
      .m_ready      (rsp_tready),
      .turn_command (turn_command)
   );

   assign rsp_tdata = {{(24 - CMD_W){1'b0}}, turn_command};

   // Command stays within twice the wrapped error range
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[16:0]) <= 17'sd51472)
                  && ($signed(rsp_tdata[16:0]) >= -17'sd51470))
      else $error("turn command out of range");

   // Command is a doubled error, so always even
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == 1'b0))
      else $error("turn command is odd");

   // Backpressure reaches the input only when the output is stalled
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled while output free");

   // A stalled output beat keeps its command
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(turn_command))
      else $error("held command changed");

endmodule

// ----- sim/turn_command_checker.sv -----
`timescale 1ns / 1ps

// Watch the csr_, req_ and rsp_ ports of the heading controller, predict the turn command
// for every accepted pose and compare it with the rsp_ beats in order.
module turn_command_checker
   import hepc_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic        csr_addr,
   input  logic [23:0] csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // robot_x[23:0], robot_y[47:24], robot_heading[63:48]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // turn_command[16:0], zero fill[23:17]
   output int          mismatch_count,
   output int          commands_owed
);

   logic signed [POS_W-1:0] goal_x_q;
   logic signed [POS_W-1:0] goal_y_q;
   logic signed [CMD_W-1:0] command_q[$];
   logic signed [CMD_W-1:0] want_cmd;
   logic signed [CMD_W-1:0] got_cmd;

   // atan(2^-n) in Q2.29: alternating series in Q0.60, truncated terms, rounded half up
   function automatic longint atan_pow2_q29(input int unsigned n);
      longint power;
      longint total;
      longint quot;
      longint k;
      total = 0;
      k = 0;
      if (n == 0) begin
         return longint'(QUARTER_PI_Q29);
      end
      if (n > 30) begin
         return 0;
      end
      power = longint'(1) << (60 - n);
      while (power != 0) begin
         quot = power / (2 * k + 1);
         if ((k % 2) == 1) begin
            total = total - quot;
         end else begin
            total = total + quot;
         end
         k = k + 1;
         power = power >>> (2 * n);
      end
      return (total + (longint'(1) << 30)) >>> 31;
   endfunction

   // Twice the wrapped angle from the heading to the goal, Q3.13
   function automatic logic signed [CMD_W-1:0] predict_turn(
      input logic signed [POS_W-1:0]  gx,
      input logic signed [POS_W-1:0]  gy,
      input logic signed [POS_W-1:0]  rx,
      input logic signed [POS_W-1:0]  ry,
      input logic signed [HEAD_W-1:0] hd
   );
      longint dx;
      longint dy;
      longint x;
      longint y;
      longint z;
      longint t;
      longint xs;
      longint ys;
      longint step_angle;
      longint angle;
      longint err;
      longint cmd;
      dx = longint'(gx) - longint'(rx);
      dy = longint'(gy) - longint'(ry);
      if (dx == 0 && dy == 0) begin
         return '0;
      end
      x = dx * 64'sd16777216;
      y = dy * 64'sd16777216;
      z = 0;
      // Fold the left half plane onto the right one
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = longint'(HALF_PI_Q29);
         end else begin
            x = -y;
            y = t;
            z = -longint'(HALF_PI_Q29);
         end
      end
      // Rotate toward the x axis, accumulating the angle
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         step_angle = atan_pow2_q29(i);
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + step_angle;
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - step_angle;
         end
      end
      angle = (z + 64'sd32768) >>> 16;
      err = angle - longint'(hd);
      if (err > longint'(PI_Q13)) begin
         err = err - longint'(TWO_PI_Q13);
      end else if (err <= -longint'(PI_Q13)) begin
         err = err + longint'(TWO_PI_Q13);
      end
      cmd = 2 * err;
      return cmd[CMD_W-1:0];
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatch_count = mismatch_count + 1;
      if (mismatch_count <= 10) begin
         $display("%0t: %s", $time, msg);
      end
   endtask

   // Track the goal, queue a command per accepted pose, retire one per rsp_ beat
   always @(posedge clock) begin
      if (reset) begin
         goal_x_q = '0;
         goal_y_q = '0;
         command_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_cmd = $signed(rsp_tdata[CMD_W-1:0]);
            if (command_q.size() == 0) begin
               flag_mismatch($sformatf("turn_command %0d with no pose outstanding", got_cmd));
            end else begin
               want_cmd = command_q.pop_front();
               if (got_cmd !== want_cmd) begin
                  flag_mismatch($sformatf("turn_command expected %0d, got %0d",
                                          want_cmd, got_cmd));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            command_q.push_back(predict_turn(goal_x_q, goal_y_q,
                                             $signed(req_tdata[23:0]),
                                             $signed(req_tdata[47:24]),
                                             $signed(req_tdata[63:48])));
         end
         if (csr_wen) begin
            if (csr_addr == CSR_GOAL_X) begin
               goal_x_q = $signed(csr_wdata);
            end else begin
               goal_y_q = $signed(csr_wdata);
            end
         end
      end
      commands_owed = command_q.size();
   end

endmodule

// ----- sim/tb_heading_error_p_controller.sv -----
`timescale 1ns / 1ps

module tb_heading_error_p_controller
   import hepc_pkg::*;
;

   localparam int STAGES = CORDIC_STAGES_DEFAULT;
   localparam int LATENCY = STAGES + 3;
   localparam int LONG_HOLD = 4 * LATENCY;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 240;
   localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
   localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;
   localparam logic signed [HEAD_W-1:0] HEAD_PI = 16'sd25736;
   localparam logic signed [HEAD_W-1:0] HEAD_NEG_PI = -16'sd25736;
   localparam logic signed [HEAD_W-1:0] HEAD_MAX = 16'sh7FFF;
   localparam logic signed [HEAD_W-1:0] HEAD_MIN = 16'sh8000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic        csr_addr = 1'b0;
   logic [23:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // robot_x[23:0], robot_y[47:24], robot_heading[63:48]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // turn_command[16:0], zero fill[23:17]

   int mismatches;
   int owed;
   bit hold_rsp = 1'b0;
   bit sender_gaps = 1'b0;
   bit receiver_gaps = 1'b0;
   logic signed [POS_W-1:0] goal_x_now = '0;
   logic signed [POS_W-1:0] goal_y_now = '0;

   always #5 clock = ~clock;

   heading_error_p_controller #(
      .CORDIC_STAGES(STAGES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   turn_command_checker #(
      .CORDIC_STAGES(STAGES)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatches),
      .commands_owed  (owed)
   );

   // Offer one pose and hold it until the beat is taken
   task automatic send_pose(input logic signed [POS_W-1:0] rx,
                            input logic signed [POS_W-1:0] ry,
                            input logic signed [HEAD_W-1:0] hd);
      req_tvalid <= 1'b1;
      req_tdata <= {hd, ry, rx};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering and wait until every command has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (owed == 0);
      repeat (LATENCY) @(posedge clock);
   endtask

   // Write both goal registers on back-to-back cycles
   task automatic set_goal(input logic signed [POS_W-1:0] gx,
                           input logic signed [POS_W-1:0] gy);
      csr_wen <= 1'b1;
      csr_addr <= CSR_GOAL_X;
      csr_wdata <= gx;
      @(posedge clock);
      csr_addr <= CSR_GOAL_Y;
      csr_wdata <= gy;
      @(posedge clock);
      csr_wen <= 1'b0;
      goal_x_now = gx;
      goal_y_now = gy;
   endtask

   // Mix far poses, poses close to or on the goal, axis-aligned ones and odd headings
   task automatic pick_pose(output logic signed [POS_W-1:0] rx,
                            output logic signed [POS_W-1:0] ry,
                            output logic signed [HEAD_W-1:0] hd);
      int off;
      case ($urandom_range(0, 9))
         5, 6, 7: begin
            off = int'($urandom_range(0, 600)) - 300;
            rx = POS_W'(goal_x_now - off);
            off = int'($urandom_range(0, 600)) - 300;
            ry = POS_W'(goal_y_now - off);
         end
         8: begin
            rx = goal_x_now;
            ry = goal_y_now;
         end
         9: begin
            if ($urandom_range(0, 1) == 0) begin
               rx = goal_x_now;
               ry = POS_W'($urandom);
            end else begin
               rx = POS_W'($urandom);
               ry = goal_y_now;
            end
         end
         default: begin
            rx = POS_W'($urandom);
            ry = POS_W'($urandom);
         end
      endcase
      case ($urandom_range(0, 9))
         0: hd = HEAD_W'($urandom);
         1: hd = ($urandom_range(0, 1) == 0) ? HEAD_PI : HEAD_NEG_PI;
         default: hd = HEAD_W'($urandom_range(0, 51472) - 25736);
      endcase
   endtask

   // Result side: long hold-off on request, random stall bursts while receiver_gaps is set
   initial begin
      bit hold_taken;
      hold_taken = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Stimulus and verdict
   initial begin
      logic signed [POS_W-1:0]  rx;
      logic signed [POS_W-1:0]  ry;
      logic signed [HEAD_W-1:0] hd;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Goal at the origin from reset: on the goal, wrap edges, all quadrants, extremes
      send_pose(24'sd0, 24'sd0, 16'sd0);
      send_pose(24'sd0, 24'sd0, HEAD_PI);
      send_pose(24'sd0, 24'sd0, HEAD_MIN);
      send_pose(-24'sd1, 24'sd0, HEAD_PI);
      send_pose(24'sd1, 24'sd0, HEAD_NEG_PI);
      send_pose(24'sd1, 24'sd0, HEAD_MAX);
      send_pose(24'sd0, -24'sd1, 16'sd0);
      send_pose(24'sd0, 24'sd1, HEAD_MIN);
      send_pose(24'sd1, 24'sd1, 16'sd0);
      send_pose(POS_MIN, POS_MIN, HEAD_PI);
      send_pose(POS_MAX, POS_MAX, HEAD_NEG_PI);
      send_pose(POS_MAX, POS_MIN, 16'sd12345);
      send_pose(POS_MIN, POS_MAX, -16'sd1);
      settle();

      // Goal in one corner: largest differences, on the goal, along an axis
      set_goal(POS_MAX, POS_MIN);
      send_pose(POS_MIN, POS_MAX, 16'sd0);
      send_pose(POS_MAX, POS_MIN, HEAD_MAX);
      send_pose(POS_MIN, POS_MIN, HEAD_MIN);
      settle();

      // Goal in the opposite corner
      set_goal(POS_MIN, POS_MAX);
      send_pose(POS_MAX, POS_MIN, 16'sd0);
      send_pose(POS_MAX, POS_MAX, HEAD_NEG_PI);
      send_pose(POS_MIN, POS_MIN, HEAD_PI);
      settle();

      // Random phases, each with its own goal
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: set_goal(POS_MIN, POS_MIN);
            1: set_goal(POS_MAX, POS_MAX);
            2: set_goal(24'sd0, 24'sd0);
            default: set_goal(POS_W'($urandom), POS_W'($urandom));
         endcase
         sender_gaps = (phase >= 1 && phase <= 6 && phase != 3);
         receiver_gaps = (phase >= 1 && phase <= 6 && phase != 4);
         if (phase == 6) begin
            hold_rsp = 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick_pose(rx, ry, hd);
            send_pose(rx, ry, hd);
            // Keep offering back to back while the result side is held off
            if (sender_gaps && !(phase == 6 && n < 80) && $urandom_range(0, 3) == 0) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end
         end
         settle();
      end

      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Timeout
   initial begin
      #5000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- heading_error_p_controller.f -----
rtl/hepc_pkg.sv
rtl/hepc_front.sv
rtl/hepc_cell.sv
rtl/hepc_finish.sv
rtl/heading_error_p_controller.sv
sim/turn_command_checker.sv
sim/tb_heading_error_p_controller.sv
